### rtl/core/triangle_point_distance_defines.svh
// Assertion macros for the triangle point distance block.
// Used by the RTL files that carry concurrent assertions; no dependencies.
`ifndef TRIANGLE_POINT_DISTANCE_DEFINES_SVH
`define TRIANGLE_POINT_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define TPD_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tpd check failed");
`define TPD_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tpd check failed");
`else
`define TPD_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define TPD_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

### rtl/core/tpd_pkg.sv
// Shared widths, vector types and vector arithmetic for the triangle point
// distance block. No dependencies.
package tpd_pkg;

  localparam int CRD_W  = 16;
  localparam int DIF_W  = 17;
  localparam int DOT_W  = 36;
  localparam int CRS_W  = 35;
  localparam int PLN_W  = 72;
  localparam int NP_W   = 52;
  localparam int NPL_W  = 26;
  localparam int NPH_W  = NP_W - 1 - NPL_W;
  localparam int SQ_W   = 70;
  localparam int DEN_W  = 68;
  localparam int NUM_W  = 102;
  localparam int QUO_W  = 34;
  localparam int ROOT_W = 17;
  localparam int REM_W  = 19;
  localparam int THK_W  = 15;
  localparam int RES_W  = 18;

  localparam logic signed [CRD_W-1:0] DIST_MAX = 16'sh7FFF;
  localparam logic signed [CRD_W-1:0] DIST_MIN = -16'sh8000;

  typedef struct packed {
    logic signed [DIF_W-1:0] x;
    logic signed [DIF_W-1:0] y;
    logic signed [DIF_W-1:0] z;
  } vec17_t;

  typedef struct packed {
    logic signed [CRS_W-1:0] x;
    logic signed [CRS_W-1:0] y;
    logic signed [CRS_W-1:0] z;
  } vec35_t;

  function automatic logic signed [DOT_W-1:0] dot17(vec17_t a, vec17_t b);
    logic signed [DOT_W-1:0] px, py, pz;
    px = DOT_W'(a.x * b.x);
    py = DOT_W'(a.y * b.y);
    pz = DOT_W'(a.z * b.z);
    return px + py + pz;
  endfunction

  function automatic vec35_t cross17(vec17_t a, vec17_t b);
    vec35_t r;
    r.x = CRS_W'(a.y * b.z) - CRS_W'(a.z * b.y);
    r.y = CRS_W'(a.z * b.x) - CRS_W'(a.x * b.z);
    r.z = CRS_W'(a.x * b.y) - CRS_W'(a.y * b.x);
    return r;
  endfunction

  function automatic logic [DEN_W-1:0] sqlen35(vec35_t v);
    logic signed [SQ_W-1:0] s;
    s = SQ_W'(v.x * v.x) + SQ_W'(v.y * v.y) + SQ_W'(v.z * v.z);
    return s[DEN_W-1:0];
  endfunction

endpackage

### rtl/core/tpd_cfg_if.sv
// Configuration write channel carrying the shell thickness.
// Depends on tpd_pkg for the field width.
interface tpd_cfg_if;
  import tpd_pkg::*;
  logic             valid;
  logic             ready;
  logic [THK_W-1:0] shell_thickness;
  modport source (output valid, output shell_thickness, input ready);
  modport sink (input valid, input shell_thickness, output ready);
endinterface

### rtl/core/tpd_in_if.sv
// Input channel: one triangle and one query point per transfer.
// Depends on tpd_pkg for the coordinate width.
interface tpd_in_if;
  import tpd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] a_x, a_y, a_z;
  logic signed [CRD_W-1:0] b_x, b_y, b_z;
  logic signed [CRD_W-1:0] c_x, c_y, c_z;
  logic signed [CRD_W-1:0] query_x, query_y, query_z;
  modport source (output valid, output a_x, a_y, a_z, b_x, b_y, b_z,
                  output c_x, c_y, c_z, query_x, query_y, query_z, input ready);
  modport sink (input valid, input a_x, a_y, a_z, b_x, b_y, b_z,
                input c_x, c_y, c_z, query_x, query_y, query_z, output ready);
endinterface

### rtl/core/tpd_out_if.sv
// Result channel: signed distance and region flags per transfer.
// Depends on tpd_pkg for the distance width.
interface tpd_out_if;
  import tpd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] distance;
  logic                    face_region;
  logic                    degenerate;
  modport source (output valid, output distance, face_region, degenerate, input ready);
  modport sink (input valid, input distance, face_region, degenerate, output ready);
endinterface

### rtl/core/tpd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tpd_pkg; the quotient is known to fit in QUO_W bits.
module tpd_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tpd_pkg::NUM_W-1:0]    num,
  input  logic [tpd_pkg::DEN_W-1:0]    den,
  output logic [tpd_pkg::QUO_W-1:0]    quo
);
  import tpd_pkg::*;

  logic [DEN_W-1:0] rem_r [1:QUO_W];
  logic [DEN_W-1:0] den_r [1:QUO_W];
  logic [QUO_W-1:0] lo_r  [1:QUO_W];
  logic [QUO_W-1:0] quo_r [1:QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic [DEN_W-1:0] rin, din;
    logic [QUO_W-1:0] lin, qin;
    logic [DEN_W:0]   t, diff;
    logic             ge;
    if (g == 0) begin : g_first
      assign rin = num[NUM_W-1:QUO_W];
      assign din = den;
      assign lin = num[QUO_W-1:0];
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem_r[g];
      assign din = den_r[g];
      assign lin = lo_r[g];
      assign qin = quo_r[g];
    end
    assign t    = {rin, lin[QUO_W-1-g]};
    assign diff = t - {1'b0, din};
    assign ge   = !diff[DEN_W];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        den_r[g+1] <= din;
        lo_r[g+1]  <= lin;
        quo_r[g+1] <= {qin[QUO_W-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QUO_W];
endmodule

### rtl/core/tpd_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor).
// Depends on tpd_pkg for the operand and root widths.
module tpd_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tpd_pkg::QUO_W-1:0]   x,
  output logic [tpd_pkg::ROOT_W-1:0]  root
);
  import tpd_pkg::*;

  logic [REM_W-1:0]  rem_r  [1:ROOT_W];
  logic [ROOT_W-1:0] root_r [1:ROOT_W];
  logic [QUO_W-1:0]  x_r    [1:ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic [REM_W-1:0]  rin;
    logic [ROOT_W-1:0] qin;
    logic [QUO_W-1:0]  xin;
    logic [REM_W+1:0]  t, trial, diff;
    logic              ge;
    if (g == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign xin = x;
    end else begin : g_rest
      assign rin = rem_r[g];
      assign qin = root_r[g];
      assign xin = x_r[g];
    end
    assign t     = {rin, xin[QUO_W-1-2*g -: 2]};
    assign trial = {(REM_W-ROOT_W)'(0), qin, 2'b01};
    assign diff  = t - trial;
    assign ge    = !diff[REM_W+1];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1]  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        root_r[g+1] <= {qin[ROOT_W-2:0], ge};
        x_r[g+1]    <= xin;
      end
    end
  end

  assign root = root_r[ROOT_W];
endmodule

### rtl/core/triangle_point_distance.sv
// Distance from a query point to a 3D triangle minus a shell thickness, Q3.12.
// Depends on tpd_pkg, the channel interfaces, tpd_div, tpd_sqrt and the defines header.
// One transfer per cycle is accepted while the output queue has room. The pipeline has
// five arithmetic stages, 34 divider stages, a minimum stage and 17 square root stages,
// then a two-entry output queue. The long divider chain is the largest part of it.
`include "triangle_point_distance_defines.svh"
module triangle_point_distance (
  input logic      clk,
  input logic      rst,
  tpd_cfg_if.sink  cfg,
  tpd_in_if.sink   items,
  tpd_out_if.source res
);
  import tpd_pkg::*;

  logic             en;
  logic [THK_W-1:0] thickness;
  logic [1:0]       cnt;

  assign cfg.ready   = 1'b1;
  assign en          = (cnt != 2'd2);
  assign items.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thickness <= '0;
    end else if (cfg.valid) begin
      thickness <= cfg.shell_thickness;
    end
  end

  // Stage A: edge and point vectors.
  logic   vld_a;
  vec17_t e_a [3];
  vec17_t p_a [3];
  vec17_t va, vb, vc, vq;

  assign va = '{DIF_W'(items.a_x), DIF_W'(items.a_y), DIF_W'(items.a_z)};
  assign vb = '{DIF_W'(items.b_x), DIF_W'(items.b_y), DIF_W'(items.b_z)};
  assign vc = '{DIF_W'(items.c_x), DIF_W'(items.c_y), DIF_W'(items.c_z)};
  assign vq = '{DIF_W'(items.query_x), DIF_W'(items.query_y), DIF_W'(items.query_z)};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en) begin
      vld_a <= items.valid;
    end
    if (en) begin
      e_a[0] <= '{vb.x - va.x, vb.y - va.y, vb.z - va.z};
      e_a[1] <= '{vc.x - vb.x, vc.y - vb.y, vc.z - vb.z};
      e_a[2] <= '{va.x - vc.x, va.y - vc.y, va.z - vc.z};
      p_a[0] <= '{vq.x - va.x, vq.y - va.y, vq.z - va.z};
      p_a[1] <= '{vq.x - vb.x, vq.y - vb.y, vq.z - vb.z};
      p_a[2] <= '{vq.x - vc.x, vq.y - vc.y, vq.z - vc.z};
    end
  end

  // Stage B: all first-order dot and cross products.
  logic                    vld_b;
  vec35_t                  nor_b;
  vec17_t                  p1_b;
  vec35_t                  cr_b  [3];
  logic signed [DOT_W-1:0] ep_b  [3];
  logic signed [DOT_W-1:0] ee_b  [3];
  logic signed [DOT_W-1:0] pp_b  [3];
  logic signed [DOT_W-1:0] e1p_b [3];
  logic signed [DOT_W-1:0] e3p_b [3];
  logic signed [DOT_W-1:0] ee3_b [3];
  logic signed [DOT_W-1:0] ee1_b [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else if (en) begin
      vld_b <= vld_a;
    end
    if (en) begin
      nor_b <= cross17(e_a[0], e_a[2]);
      p1_b  <= p_a[0];
      for (int k = 0; k < 3; k++) begin
        cr_b[k]  <= cross17(p_a[k], e_a[k]);
        ep_b[k]  <= dot17(e_a[k], p_a[k]);
        ee_b[k]  <= dot17(e_a[k], e_a[k]);
        pp_b[k]  <= dot17(p_a[k], p_a[k]);
        e1p_b[k] <= dot17(e_a[0], p_a[k]);
        e3p_b[k] <= dot17(e_a[2], p_a[k]);
        ee3_b[k] <= dot17(e_a[k], e_a[2]);
        ee1_b[k] <= dot17(e_a[k], e_a[0]);
      end
    end
  end

  // Stage C: plane test products, normal projection and squared lengths.
  logic                    vld_c, deg_c;
  logic signed [PLN_W-1:0] pa_c [3];
  logic signed [PLN_W-1:0] pb_c [3];
  logic signed [NP_W-1:0]  np_c;
  logic [DEN_W-1:0]        nn_c;
  logic [DEN_W-1:0]        crsq_c [3];
  logic signed [DOT_W-1:0] ep_c [3];
  logic signed [DOT_W-1:0] ee_c [3];
  logic signed [DOT_W-1:0] pp_c [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else if (en) begin
      vld_c <= vld_b;
    end
    if (en) begin
      deg_c <= (nor_b.x == '0) && (nor_b.y == '0) && (nor_b.z == '0);
      np_c  <= NP_W'(nor_b.x * p1_b.x) + NP_W'(nor_b.y * p1_b.y)
             + NP_W'(nor_b.z * p1_b.z);
      nn_c  <= sqlen35(nor_b);
      for (int k = 0; k < 3; k++) begin
        pa_c[k]   <= PLN_W'(e1p_b[k] * ee3_b[k]);
        pb_c[k]   <= PLN_W'(e3p_b[k] * ee1_b[k]);
        crsq_c[k] <= sqlen35(cr_b[k]);
        ep_c[k]   <= ep_b[k];
        ee_c[k]   <= ee_b[k];
        pp_c[k]   <= pp_b[k];
      end
    end
  end

  // Stage D: region decision, edge operands and partial squares of the projection.
  logic                   vld_d, deg_d, face_d;
  logic [NUM_W-1:0]       num_d [3];
  logic [DEN_W-1:0]       den_d [3];
  logic [2:0]             pln_ok;
  logic                   face;
  logic [NUM_W-1:0]       num_n [3];
  logic [DEN_W-1:0]       den_n [3];
  logic [NP_W-2:0]        np_abs;
  logic [NPH_W-1:0]       np_hi;
  logic [NPL_W-1:0]       np_lo;
  logic [2*NPH_W-1:0]     sq_hh_d;
  logic [NPH_W+NPL_W-1:0] sq_hl_d;
  logic [2*NPL_W-1:0]     sq_ll_d;
  logic [DEN_W-1:0]       nn_d;

  assign np_abs = (NP_W-1)'(np_c[NP_W-1] ? -np_c : np_c);
  assign np_hi  = np_abs[NP_W-2:NPL_W];
  assign np_lo  = np_abs[NPL_W-1:0];

  always_comb begin
    logic signed [PLN_W:0] t;
    for (int k = 0; k < 3; k++) begin
      t = (PLN_W+1)'(pa_c[k]) - (PLN_W+1)'(pb_c[k]);
      pln_ok[k] = !t[PLN_W];
    end
    face = &pln_ok;
    for (int k = 0; k < 3; k++) begin
      if (ep_c[k] <= 0) begin
        num_n[k] = {(NUM_W-DOT_W)'(0), pp_c[k]};
        den_n[k] = DEN_W'(1);
      end else if (ep_c[k] >= ee_c[k]) begin
        num_n[k] = {(NUM_W-DOT_W)'(0), pp_c[(k+1)%3]};
        den_n[k] = DEN_W'(1);
      end else begin
        num_n[k] = {(NUM_W-DEN_W)'(0), crsq_c[k]};
        den_n[k] = {(DEN_W-QUO_W)'(0), ee_c[k][QUO_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
    end else if (en) begin
      vld_d <= vld_c;
    end
    if (en) begin
      deg_d   <= deg_c;
      face_d  <= face;
      sq_hh_d <= (2*NPH_W)'(np_hi) * (2*NPH_W)'(np_hi);
      sq_hl_d <= (NPH_W+NPL_W)'(np_hi) * (NPH_W+NPL_W)'(np_lo);
      sq_ll_d <= (2*NPL_W)'(np_lo) * (2*NPL_W)'(np_lo);
      nn_d    <= nn_c;
      for (int k = 0; k < 3; k++) begin
        num_d[k] <= num_n[k];
        den_d[k] <= den_n[k];
      end
    end
  end

  // Stage E: the squared projection is summed and replaces lane 0 in the face region.
  logic             vld_e, deg_e, face_e;
  logic [NUM_W-1:0] num_e [3];
  logic [DEN_W-1:0] den_e [3];
  logic [NUM_W-1:0] np2;

  assign np2 = {sq_hh_d, (2*NPL_W)'(0)}
             + {(NUM_W-NPH_W-2*NPL_W-1)'(0), sq_hl_d, (NPL_W+1)'(0)}
             + {(NUM_W-2*NPL_W)'(0), sq_ll_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_e <= 1'b0;
    end else if (en) begin
      vld_e <= vld_d;
    end
    if (en) begin
      deg_e    <= deg_d;
      face_e   <= face_d;
      num_e[0] <= face_d ? np2 : num_d[0];
      den_e[0] <= face_d ? nn_d : den_d[0];
      for (int k = 1; k < 3; k++) begin
        num_e[k] <= num_d[k];
        den_e[k] <= den_d[k];
      end
    end
  end

  // Divider lanes; lane 0 also serves the face distance.
  logic [QUO_W-1:0] quo [3];
  for (genvar k = 0; k < 3; k++) begin : g_lane
    tpd_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_e[k]),
      .den (den_e[k]),
      .quo (quo[k])
    );
  end

  logic dv_v [1:QUO_W];
  logic dv_f [1:QUO_W];
  logic dv_g [1:QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= QUO_W; i++) begin
        dv_v[i] <= 1'b0;
      end
    end else if (en) begin
      dv_v[1] <= vld_e;
      for (int i = 2; i <= QUO_W; i++) begin
        dv_v[i] <= dv_v[i-1];
      end
    end
    if (en) begin
      dv_f[1] <= face_e;
      dv_g[1] <= deg_e;
      for (int i = 2; i <= QUO_W; i++) begin
        dv_f[i] <= dv_f[i-1];
        dv_g[i] <= dv_g[i-1];
      end
    end
  end

  // Minimum stage; in the face region lane 0 passes through instead.
  logic             vld_m, face_m, deg_m;
  logic [QUO_W-1:0] d2_m;
  logic [QUO_W-1:0] m01;

  assign m01 = (quo[0] < quo[1]) ? quo[0] : quo[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m <= 1'b0;
    end else if (en) begin
      vld_m <= dv_v[QUO_W];
    end
    if (en) begin
      face_m <= dv_f[QUO_W];
      deg_m  <= dv_g[QUO_W];
      if (dv_f[QUO_W]) begin
        d2_m <= quo[0];
      end else begin
        d2_m <= (quo[2] < m01) ? quo[2] : m01;
      end
    end
  end

  logic [ROOT_W-1:0] root;
  tpd_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (d2_m),
    .root (root)
  );

  logic sq_v [1:ROOT_W];
  logic sq_f [1:ROOT_W];
  logic sq_g [1:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= ROOT_W; i++) begin
        sq_v[i] <= 1'b0;
      end
    end else if (en) begin
      sq_v[1] <= vld_m;
      for (int i = 2; i <= ROOT_W; i++) begin
        sq_v[i] <= sq_v[i-1];
      end
    end
    if (en) begin
      sq_f[1] <= face_m;
      sq_g[1] <= deg_m;
      for (int i = 2; i <= ROOT_W; i++) begin
        sq_f[i] <= sq_f[i-1];
        sq_g[i] <= sq_g[i-1];
      end
    end
  end

  // Thickness, saturation and the degenerate override.
  logic signed [RES_W-1:0] diff;
  logic signed [CRD_W-1:0] dist_n;
  logic                    face_n, deg_n, push, pop;

  assign diff = $signed({1'b0, root}) - $signed({(RES_W-THK_W)'(0), thickness});

  always_comb begin
    deg_n  = sq_g[ROOT_W];
    face_n = sq_f[ROOT_W] && !deg_n;
    if (deg_n) begin
      dist_n = DIST_MAX;
    end else if (diff > RES_W'(DIST_MAX)) begin
      dist_n = DIST_MAX;
    end else if (diff < RES_W'(DIST_MIN)) begin
      dist_n = DIST_MIN;
    end else begin
      dist_n = diff[CRD_W-1:0];
    end
  end

  assign push = en && sq_v[ROOT_W];
  assign pop  = res.valid && res.ready;

  // Two-entry output queue.
  logic signed [CRD_W-1:0] t_dist;
  logic                    t_face, t_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case (cnt)
        2'd0: if (push) cnt <= 2'd1;
        2'd1: if (push && !pop) cnt <= 2'd2;
              else if (!push && pop) cnt <= 2'd0;
        2'd2: if (pop) cnt <= 2'd1;
        default: cnt <= 2'd0;
      endcase
    end
    if ((cnt == 2'd0 && push) || (cnt == 2'd1 && push && pop)) begin
      res.distance    <= dist_n;
      res.face_region <= face_n;
      res.degenerate  <= deg_n;
    end else if (cnt == 2'd2 && pop) begin
      res.distance    <= t_dist;
      res.face_region <= t_face;
      res.degenerate  <= t_deg;
    end
    if (cnt == 2'd1 && push && !pop) begin
      t_dist <= dist_n;
      t_face <= face_n;
      t_deg  <= deg_n;
    end
  end

  assign res.valid = (cnt != 2'd0);

  `TPD_ASSERT_IMP(a_cnt_range, clk, rst, 1'b1, cnt != 2'd3)
  `TPD_ASSERT_IMP(a_full_blocks, clk, rst, cnt == 2'd2, !items.ready)
  `TPD_ASSERT_IMP(a_degen_out, clk, rst, res.valid && res.degenerate, res.distance == DIST_MAX && !res.face_region)
  `TPD_ASSERT_NXT(a_stall_holds, clk, rst, !en, $stable(vld_b) && $stable(vld_m))
endmodule

### test/tb_triangle_point_distance.sv
// Testbench for the point to triangle distance block: drives triangles and
// query points, predicts distance and region flags, and checks every transfer.
// Depends on tpd_pkg and the channel interfaces tpd_cfg_if, tpd_in_if, tpd_out_if.
`timescale 1ns / 100ps
module tb_triangle_point_distance;
  import tpd_pkg::*;

  typedef struct {
    logic signed [CRD_W-1:0] c [12];
  } tri_t;

  typedef struct {
    logic signed [CRD_W-1:0] distance;
    logic                    face_region;
    logic                    degenerate;
  } dist_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  tpd_cfg_if cfg ();
  tpd_in_if  items ();
  tpd_out_if res ();

  triangle_point_distance dut (.clk(clk), .rst(rst), .cfg(cfg), .items(items), .res(res));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [THK_W-1:0] thickness;
  dist_t            pending_dist [$];
  int               mismatches = 0;
  int               burst_left = 0;
  int               stall_mode = 0;

  // Fully exact predictor in wide signed arithmetic.
  function automatic logic [127:0] isqrt_floor(logic [127:0] x);
    logic [127:0] r, b;
    r = 0;
    for (int i = 40; i >= 0; i--) begin
      b = r | (128'd1 << i);
      if (b * b <= x) r = b;
    end
    return r;
  endfunction

  function automatic logic signed [127:0] dot(logic signed [127:0] a [3],
                                               logic signed [127:0] b [3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic logic signed [127:0] seg_sq(logic signed [127:0] p [3],
                                                  logic signed [127:0] e [3]);
    logic signed [127:0] ep, ee, d [3], cx, cy, cz;
    ep = dot(e, p);
    ee = dot(e, e);
    if (ep <= 0) return dot(p, p);
    if (ep >= ee) begin
      for (int i = 0; i < 3; i++) d[i] = p[i] - e[i];
      return dot(d, d);
    end
    cx = p[1] * e[2] - p[2] * e[1];
    cy = p[2] * e[0] - p[0] * e[2];
    cz = p[0] * e[1] - p[1] * e[0];
    return (cx * cx + cy * cy + cz * cz) / ee;
  endfunction

  function automatic dist_t predict_distance(tri_t t);
    logic signed [127:0] va [3], vb [3], vc [3], q [3];
    logic signed [127:0] e1 [3], e2 [3], e3 [3], p1 [3], p2 [3], p3 [3], nr [3];
    logic signed [127:0] d2, np, sa, sb, sc, r;
    logic                face;
    dist_t               o;
    for (int i = 0; i < 3; i++) begin
      va[i] = t.c[i]; vb[i] = t.c[3+i]; vc[i] = t.c[6+i]; q[i] = t.c[9+i];
    end
    for (int i = 0; i < 3; i++) begin
      e1[i] = vb[i] - va[i]; p1[i] = q[i] - va[i];
      e2[i] = vc[i] - vb[i]; p2[i] = q[i] - vb[i];
      e3[i] = va[i] - vc[i]; p3[i] = q[i] - vc[i];
    end
    nr[0] = e1[1] * e3[2] - e1[2] * e3[1];
    nr[1] = e1[2] * e3[0] - e1[0] * e3[2];
    nr[2] = e1[0] * e3[1] - e1[1] * e3[0];
    if (nr[0] == 0 && nr[1] == 0 && nr[2] == 0) begin
      o.distance = DIST_MAX;
      o.face_region = 1'b0;
      o.degenerate = 1'b1;
      return o;
    end
    face = (dot(e1, p1) * dot(e1, e3) - dot(e3, p1) * dot(e1, e1)) >= 0 &&
           (dot(e1, p2) * dot(e2, e3) - dot(e3, p2) * dot(e2, e1)) >= 0 &&
           (dot(e1, p3) * dot(e3, e3) - dot(e3, p3) * dot(e3, e1)) >= 0;
    if (face) begin
      np = dot(nr, p1);
      d2 = (np * np) / dot(nr, nr);
    end else begin
      sa = seg_sq(p1, e1);
      sb = seg_sq(p2, e2);
      sc = seg_sq(p3, e3);
      d2 = sa < sb ? sa : sb;
      if (sc < d2) d2 = sc;
    end
    r = $signed(isqrt_floor(d2)) - $signed({113'd0, thickness});
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    o.distance = r[15:0];
    o.face_region = face;
    o.degenerate = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic idle_items();
    items.valid <= 1'b0;
  endtask

  task automatic send_triangle(tri_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        items.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    {items.a_x, items.a_y, items.a_z} <= {t.c[0], t.c[1], t.c[2]};
    {items.b_x, items.b_y, items.b_z} <= {t.c[3], t.c[4], t.c[5]};
    {items.c_x, items.c_y, items.c_z} <= {t.c[6], t.c[7], t.c[8]};
    {items.query_x, items.query_y, items.query_z} <= {t.c[9], t.c[10], t.c[11]};
    items.valid <= 1'b1;
    do @(posedge clk); while (!items.ready);
    pending_dist.insert(pending_dist.size(), predict_distance(t));
  endtask

  task automatic write_thickness(logic [THK_W-1:0] v);
    idle_items();
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    cfg.shell_thickness <= v;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    thickness = v;
  endtask

  always @(posedge clk) begin
    dist_t w;
    if (!rst && res.valid && res.ready) begin
      if (pending_dist.size() == 0) begin
        report_mismatch("unexpected transfer", res.distance, 0);
      end else begin
        w = pending_dist.pop_front();
        if (res.distance !== w.distance) report_mismatch("distance", res.distance, w.distance);
        if (res.face_region !== w.face_region)
          report_mismatch("face_region", res.face_region, w.face_region);
        if (res.degenerate !== w.degenerate)
          report_mismatch("degenerate", res.degenerate, w.degenerate);
      end
    end
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: res.ready <= 1'b1;
      1: res.ready <= $urandom_range(0, 1);
      2: res.ready <= ($urandom_range(0, 7) != 0);
      default: res.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic tri_t make_triangle(int spread);
    tri_t t;
    for (int i = 0; i < 12; i++) begin
      if (spread == 0) t.c[i] = CRD_W'($urandom);
      else t.c[i] = CRD_W'($signed($urandom_range(0, 2 * spread)) - spread);
    end
    return t;
  endfunction

  task automatic test_extremes();
    tri_t t;
    for (int i = 0; i < 12; i++) t.c[i] = 16'sh7FFF;
    send_triangle(t);
    for (int i = 0; i < 12; i++) t.c[i] = (i % 2) ? 16'sh8000 : 16'sh7FFF;
    send_triangle(t);
    for (int i = 0; i < 12; i++) t.c[i] = 0;
    t.c[3] = 16'sh7FFF; t.c[7] = 16'sh7FFF; t.c[9] = 16'sh8000; t.c[10] = 16'sh8000;
    t.c[11] = 16'sh8000;
    send_triangle(t);
    t.c[9] = 16'sh7FFF; t.c[10] = 16'sh7FFF; t.c[11] = 16'sh7FFF;
    send_triangle(t);
  endtask

  task automatic test_regions();
    tri_t t;
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 12; i++) t.c[i] = 0;
      t.c[3] = 4096; t.c[7] = 4096;
      case (k)
        0: begin t.c[9] = 1000; t.c[10] = 1000; t.c[11] = 2000; end
        1: begin t.c[9] = 0; t.c[10] = 0; t.c[11] = 0; end
        2: begin t.c[9] = -3000; t.c[10] = -3000; t.c[11] = 100; end
        3: begin t.c[9] = 8000; t.c[10] = -100; t.c[11] = 0; end
        4: begin t.c[9] = 2048; t.c[10] = -500; t.c[11] = 300; end
        5: begin t.c[9] = 3000; t.c[10] = 3000; t.c[11] = -50; end
        6: begin t.c[9] = 2048; t.c[10] = 2048; t.c[11] = 7; end
        default: begin t.c[9] = 4096; t.c[10] = 0; t.c[11] = 0; end
      endcase
      send_triangle(t);
    end
  endtask

  task automatic test_degenerate();
    tri_t t;
    t = make_triangle(0);
    for (int i = 0; i < 3; i++) t.c[3+i] = t.c[i];
    send_triangle(t);
    t = make_triangle(0);
    for (int i = 0; i < 3; i++) t.c[6+i] = CRD_W'(2 * t.c[3+i] - t.c[i]);
    for (int i = 0; i < 3; i++) begin t.c[i] = CRD_W'(100 * i); t.c[3+i] = CRD_W'(200 * i);
      t.c[6+i] = CRD_W'(-300 * i); end
    send_triangle(t);
    for (int i = 0; i < 9; i++) t.c[i] = 16'sh8000;
    send_triangle(t);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0: send_triangle(make_triangle(0));
        1: send_triangle(make_triangle(6000));
        2: send_triangle(make_triangle(300));
        default: send_triangle(make_triangle(32767));
      endcase
    end
  endtask

  initial begin
    items.valid = 1'b0;
    cfg.valid = 1'b0;
    cfg.shell_thickness = '0;
    res.ready = 1'b1;
    {items.a_x, items.a_y, items.a_z, items.b_x, items.b_y, items.b_z} = '0;
    {items.c_x, items.c_y, items.c_z, items.query_x, items.query_y, items.query_z} = '0;
    thickness = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_regions();
    test_degenerate();
    test_random(250);
    write_thickness(15'h7FFF);
    test_extremes();
    test_random(250);
    write_thickness(15'd4096);
    test_regions();
    test_random(250);
    write_thickness(THK_W'($urandom_range(0, 32767)));
    test_random(150);
    write_thickness('0);
    test_random(100);
    idle_items();
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
